>>> src/command_line_tokenizer_unit_macros.svh
// Assertion helpers for the command line tokenizer
`ifndef COMMAND_LINE_TOKENIZER_UNIT_MACROS_SVH
`define COMMAND_LINE_TOKENIZER_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define CLT_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("clt: check failed");

// Next-cycle implication, checked out of reset
`define CLT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("clt: check failed");

`endif

>>> src/clt_pkg.sv
package clt_pkg;

    localparam int NAME_BYTES       = 16;
    localparam int FIRST_ARG_BYTES  = 64;
    localparam int SECOND_ARG_BYTES = 128;

    // Field widths of the beats
    localparam int BYTE_W       = 8;
    localparam int FIELD_ID_W   = 2;
    localparam int CHAR_INDEX_W = 7;
    localparam int NAME_LEN_W   = 4;
    localparam int FIRST_LEN_W  = 6;
    localparam int SECOND_LEN_W = 7;

    // Name counter must hold NAME_BYTES itself (too-long mark)
    localparam int NAME_CNT_W   = $clog2(NAME_BYTES + 1);
    localparam int FIRST_CNT_W  = (FIRST_ARG_BYTES > 1) ? $clog2(FIRST_ARG_BYTES) : 1;
    localparam int SECOND_CNT_W = (SECOND_ARG_BYTES > 1) ? $clog2(SECOND_ARG_BYTES) : 1;

    localparam logic [NAME_CNT_W-1:0]   NAME_FULL   = NAME_CNT_W'(NAME_BYTES);
    localparam logic [NAME_CNT_W-1:0]   NAME_LAST   = NAME_CNT_W'(NAME_BYTES - 1);
    localparam logic [FIRST_CNT_W-1:0]  FIRST_LAST  = FIRST_CNT_W'(FIRST_ARG_BYTES - 1);
    localparam logic [SECOND_CNT_W-1:0] SECOND_LAST = SECOND_CNT_W'(SECOND_ARG_BYTES - 1);

    localparam logic [BYTE_W-1:0] QUOTE_CH = 8'h22;
    localparam logic [BYTE_W-1:0] END_CH   = 8'h00;
    localparam logic [BYTE_W-1:0] CASE_GAP = 8'h20;

    localparam logic [FIELD_ID_W-1:0] FIELD_NAME   = 2'd0;
    localparam logic [FIELD_ID_W-1:0] FIELD_FIRST  = 2'd1;
    localparam logic [FIELD_ID_W-1:0] FIELD_SECOND = 2'd2;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef struct packed {
        logic                    is_status;
        logic [FIELD_ID_W-1:0]   field_id;
        logic [CHAR_INDEX_W-1:0] char_index;
        logic [BYTE_W-1:0]       char_value;
        logic                    status_code;
        logic [NAME_LEN_W-1:0]   name_length;
        logic [FIRST_LEN_W-1:0]  first_arg_length;
        logic [SECOND_LEN_W-1:0] second_arg_length;
    } t_result;

    function automatic logic is_ws(input logic [BYTE_W-1:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

endpackage

>>> src/clt_ifs.sv
interface clt_byte_if;
    logic                         valid;
    logic                         ready;
    logic [clt_pkg::BYTE_W-1:0]   in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface clt_result_if;
    logic                               valid;
    logic                               ready;
    logic                               is_status;
    logic [clt_pkg::FIELD_ID_W-1:0]     field_id;
    logic [clt_pkg::CHAR_INDEX_W-1:0]   char_index;
    logic [clt_pkg::BYTE_W-1:0]         char_value;
    logic                               status_code;
    logic [clt_pkg::NAME_LEN_W-1:0]     name_length;
    logic [clt_pkg::FIRST_LEN_W-1:0]    first_arg_length;
    logic [clt_pkg::SECOND_LEN_W-1:0]   second_arg_length;

    modport source (
        output valid, input ready,
        output is_status, output field_id, output char_index, output char_value,
        output status_code, output name_length, output first_arg_length,
        output second_arg_length
    );
    modport sink (
        input valid, output ready,
        input is_status, input field_id, input char_index, input char_value,
        input status_code, input name_length, input first_arg_length,
        input second_arg_length
    );
endinterface

>>> src/clt_parse.sv
module clt_parse (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_adv,
    input  logic                       i_in_valid,
    input  logic [clt_pkg::BYTE_W-1:0] i_byte,
    output logic                       o_res_valid,
    output clt_pkg::t_result           o_res
);

    typedef enum logic [2:0] {
        PH_LEAD  = 3'd0,
        PH_NAME  = 3'd1,
        PH_GAP1  = 3'd2,
        PH_QUOTE = 3'd3,
        PH_BARE  = 3'd4,
        PH_GAP2  = 3'd5,
        PH_REST  = 3'd6
    } t_phase;

    t_phase                               r_phase, n_phase;
    logic [clt_pkg::NAME_CNT_W-1:0]       r_name_count, n_name_count;
    logic [clt_pkg::FIRST_CNT_W-1:0]      r_first_count, n_first_count;
    logic [clt_pkg::SECOND_CNT_W-1:0]     r_second_count, n_second_count;
    logic                                 r_res_valid, n_emit;
    clt_pkg::t_result                     r_res, n_res;
    logic                                 c_end, c_ws;
    logic [clt_pkg::BYTE_W-1:0]           c_upper;

    function automatic clt_pkg::t_result char_res(
        input logic [clt_pkg::FIELD_ID_W-1:0]   field,
        input logic [clt_pkg::CHAR_INDEX_W-1:0] idx,
        input logic [clt_pkg::BYTE_W-1:0]       ch
    );
        clt_pkg::t_result r;
        r            = '0;
        r.field_id   = field;
        r.char_index = idx;
        r.char_value = ch;
        return r;
    endfunction

    function automatic clt_pkg::t_result stat_res(
        input logic                             err,
        input logic [clt_pkg::NAME_LEN_W-1:0]   nl,
        input logic [clt_pkg::FIRST_LEN_W-1:0]  a1,
        input logic [clt_pkg::SECOND_LEN_W-1:0] a2
    );
        clt_pkg::t_result r;
        r                   = '0;
        r.is_status         = 1'b1;
        r.status_code       = err;
        r.name_length       = nl;
        r.first_arg_length  = a1;
        r.second_arg_length = a2;
        return r;
    endfunction

    assign c_end   = (i_byte == clt_pkg::END_CH);
    assign c_ws    = clt_pkg::is_ws(i_byte);
    assign c_upper = (i_byte inside {[8'h61:8'h7A]}) ? (i_byte - clt_pkg::CASE_GAP) : i_byte;

    always_comb begin
        n_phase        = r_phase;
        n_name_count   = r_name_count;
        n_first_count  = r_first_count;
        n_second_count = r_second_count;
        n_emit         = 1'b0;
        n_res          = '0;

        if (c_end) begin
            // every phase restarts on the terminator with one status beat
            n_phase        = PH_LEAD;
            n_name_count   = '0;
            n_first_count  = '0;
            n_second_count = '0;
            n_emit         = 1'b1;
            case (r_phase)
                PH_NAME: begin
                    if (r_name_count >= clt_pkg::NAME_FULL) begin
                        n_res = stat_res(clt_pkg::STATUS_ERR, '0, '0, '0);
                    end else begin
                        n_res = stat_res(clt_pkg::STATUS_OK,
                            clt_pkg::NAME_LEN_W'(r_name_count),
                            clt_pkg::FIRST_LEN_W'(r_first_count),
                            clt_pkg::SECOND_LEN_W'(r_second_count));
                    end
                end
                PH_QUOTE: begin
                    n_res = stat_res(clt_pkg::STATUS_ERR,
                        clt_pkg::NAME_LEN_W'(r_name_count), '0, '0);
                end
                PH_GAP1, PH_BARE, PH_GAP2, PH_REST: begin
                    n_res = stat_res(clt_pkg::STATUS_OK,
                        clt_pkg::NAME_LEN_W'(r_name_count),
                        clt_pkg::FIRST_LEN_W'(r_first_count),
                        clt_pkg::SECOND_LEN_W'(r_second_count));
                end
                default: begin
                    n_res = stat_res(clt_pkg::STATUS_ERR, '0, '0, '0);
                end
            endcase
        end else begin
            case (r_phase)
                PH_NAME: begin
                    if (c_ws) begin
                        if (r_name_count < clt_pkg::NAME_FULL) begin
                            n_phase = PH_GAP1;
                        end
                    end else if (r_name_count >= clt_pkg::NAME_LAST) begin
                        n_name_count = clt_pkg::NAME_FULL;
                    end else begin
                        n_emit       = 1'b1;
                        n_res        = char_res(clt_pkg::FIELD_NAME,
                            clt_pkg::CHAR_INDEX_W'(r_name_count), c_upper);
                        n_name_count = r_name_count + 1'b1;
                    end
                end
                PH_GAP1, PH_QUOTE, PH_BARE: begin
                    if (r_phase == PH_GAP1 && c_ws) begin
                        n_phase = PH_GAP1;
                    end else if (r_phase == PH_GAP1 && i_byte == clt_pkg::QUOTE_CH) begin
                        n_phase = PH_QUOTE;
                    end else if (r_phase == PH_QUOTE && i_byte == clt_pkg::QUOTE_CH) begin
                        n_phase = PH_GAP2;
                    end else if (r_phase == PH_BARE && c_ws) begin
                        n_phase = PH_GAP2;
                    end else begin
                        if (r_phase == PH_GAP1) begin
                            n_phase = PH_BARE;
                        end
                        if (r_first_count < clt_pkg::FIRST_LAST) begin
                            n_emit        = 1'b1;
                            n_res         = char_res(clt_pkg::FIELD_FIRST,
                                clt_pkg::CHAR_INDEX_W'(r_first_count), i_byte);
                            n_first_count = r_first_count + 1'b1;
                        end
                    end
                end
                PH_GAP2, PH_REST: begin
                    if (!(r_phase == PH_GAP2 && c_ws)) begin
                        n_phase = PH_REST;
                        if (r_second_count < clt_pkg::SECOND_LAST) begin
                            n_emit         = 1'b1;
                            n_res          = char_res(clt_pkg::FIELD_SECOND,
                                clt_pkg::CHAR_INDEX_W'(r_second_count), i_byte);
                            n_second_count = r_second_count + 1'b1;
                        end
                    end
                end
                default: begin
                    // leading whitespace, also any stray phase code
                    if (c_ws) begin
                        n_phase = PH_LEAD;
                    end else begin
                        n_phase        = PH_NAME;
                        n_first_count  = '0;
                        n_second_count = '0;
                        n_emit         = 1'b1;
                        n_res          = char_res(clt_pkg::FIELD_NAME, '0, c_upper);
                        n_name_count   = clt_pkg::NAME_CNT_W'(1);
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_res <= n_res;
        end
        if (!i_rst_n) begin
            r_phase        <= PH_LEAD;
            r_name_count   <= '0;
            r_first_count  <= '0;
            r_second_count <= '0;
            r_res_valid    <= 1'b0;
        end else if (i_adv) begin
            r_res_valid <= i_in_valid && n_emit;
            if (i_in_valid) begin
                r_phase        <= n_phase;
                r_name_count   <= n_name_count;
                r_first_count  <= n_first_count;
                r_second_count <= n_second_count;
            end
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

>>> src/command_line_tokenizer_unit.sv
// Command line tokenizer.
// i_in (valid/ready) takes one line byte per beat; byte 0 ends the line.
// o_out (valid/ready) gives zero or one beat per input byte: a character
// beat (field_id 0 name upper-cased, 1 arg1, 2 arg2, with its char_index)
// or, on the terminator, a status beat with ok/error and the three lengths.
// Separating whitespace, arg1's quotes and bytes past capacity give no beat.
// A byte passes the input register, then the result register, before its
// beat is offered on o_out.
// Throughput: one byte per cycle while o_out does not stall; the per-byte
// phase update is a single level of decode between the two registers.
// Reset (synchronous, active low) returns the parser to the leading
// whitespace phase with all counts cleared and drops any held beat.
// When o_out stalls the result register holds, the input register keeps
// one further byte, and i_in.ready falls until the result is taken.
`include "command_line_tokenizer_unit_macros.svh"

module command_line_tokenizer_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    clt_byte_if.sink      i_in,
    clt_result_if.source  o_out
);

    logic                       r_in_valid;
    logic [clt_pkg::BYTE_W-1:0] r_in_byte;
    logic                       res_valid;
    logic                       adv;
    clt_pkg::t_result           res;

    // result slot is free or being drained this cycle
    assign adv        = !res_valid || o_out.ready;
    assign i_in.ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (i_in.ready) begin
            r_in_byte <= i_in.in_byte;
        end
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    clt_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_in_valid  (r_in_valid),
        .i_byte      (r_in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    assign o_out.valid             = res_valid;
    assign o_out.is_status         = res.is_status;
    assign o_out.field_id          = res.field_id;
    assign o_out.char_index        = res.char_index;
    assign o_out.char_value        = res.char_value;
    assign o_out.status_code       = res.status_code;
    assign o_out.name_length       = res.name_length;
    assign o_out.first_arg_length  = res.first_arg_length;
    assign o_out.second_arg_length = res.second_arg_length;

    `CLT_ASSERT_NOW(a_status_no_char, i_clk, i_rst_n, res_valid && res.is_status, res.field_id == '0 && res.char_index == '0 && res.char_value == '0)
    `CLT_ASSERT_NOW(a_char_no_status, i_clk, i_rst_n, res_valid && !res.is_status, res.field_id != 2'd3 && res.status_code == clt_pkg::STATUS_OK && res.name_length == '0)
    `CLT_ASSERT_NOW(a_name_index, i_clk, i_rst_n, res_valid && !res.is_status && res.field_id == clt_pkg::FIELD_NAME, int'(res.char_index) < clt_pkg::NAME_BYTES - 1)
    `CLT_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, r_in_valid && !adv, r_in_valid && $stable(r_in_byte))

endmodule

>>> tb/sv/command_line_tokenizer_unit_checker.sv
module command_line_tokenizer_unit_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    clt_byte_if   i_in,
    clt_result_if i_out,
    output int    o_fail_count,
    output int    o_tokens_pending
);
    import clt_pkg::*;

    localparam logic [BYTE_W-1:0] SPACE_CH = 8'h20;
    localparam logic [BYTE_W-1:0] TAB_CH   = 8'h09;
    localparam logic [BYTE_W-1:0] CR_CH    = 8'h0D;
    localparam logic [BYTE_W-1:0] LOWER_A  = 8'h61;
    localparam logic [BYTE_W-1:0] LOWER_Z  = 8'h7A;

    typedef enum logic [2:0] {
        SCAN_LEAD, SCAN_NAME, SCAN_GAP1, SCAN_QUOTED, SCAN_BARE, SCAN_GAP2, SCAN_TAIL
    } scan_phase_e;

    scan_phase_e scan_phase;
    int          name_len;
    int          first_len;
    int          second_len;
    int          fails;
    t_result     token_beats[$];
    t_result     want;
    t_result     seen;

    function automatic bit is_blank(input logic [BYTE_W-1:0] c);
        return (c == SPACE_CH) || ((c >= TAB_CH) && (c <= CR_CH));
    endfunction

    function automatic bit close_line(output t_result r, input logic err,
                                      input int nl, input int a1, input int a2);
        r                   = '0;
        r.is_status         = 1'b1;
        r.status_code       = err;
        r.name_length       = NAME_LEN_W'(nl);
        r.first_arg_length  = FIRST_LEN_W'(a1);
        r.second_arg_length = SECOND_LEN_W'(a2);
        scan_phase = SCAN_LEAD;
        name_len   = 0;
        first_len  = 0;
        second_len = 0;
        return 1'b1;
    endfunction

    function automatic bit close_ok(output t_result r);
        return close_line(r, STATUS_OK, name_len, first_len, second_len);
    endfunction

    function automatic bit field_char(output t_result r, input logic [FIELD_ID_W-1:0] fld,
                                      input int idx, input logic [BYTE_W-1:0] ch);
        r            = '0;
        r.field_id   = fld;
        r.char_index = CHAR_INDEX_W'(idx);
        r.char_value = ch;
        return 1'b1;
    endfunction

    function automatic bit name_char(output t_result r, input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] up;
        r  = '0;
        up = c;
        // past capacity: mark as too long, nothing emitted
        if (name_len >= NAME_BYTES - 1) begin
            name_len = NAME_BYTES;
            return 1'b0;
        end
        if ((c >= LOWER_A) && (c <= LOWER_Z)) up = c - CASE_GAP;
        void'(field_char(r, FIELD_NAME, name_len, up));
        name_len++;
        return 1'b1;
    endfunction

    function automatic bit first_char(output t_result r, input logic [BYTE_W-1:0] c);
        r = '0;
        if (first_len >= FIRST_ARG_BYTES - 1) return 1'b0;
        void'(field_char(r, FIELD_FIRST, first_len, c));
        first_len++;
        return 1'b1;
    endfunction

    function automatic bit second_char(output t_result r, input logic [BYTE_W-1:0] c);
        r = '0;
        if (second_len >= SECOND_ARG_BYTES - 1) return 1'b0;
        void'(field_char(r, FIELD_SECOND, second_len, c));
        second_len++;
        return 1'b1;
    endfunction

    // One line byte in, zero or one beat out
    function automatic bit tokenize_byte(input logic [BYTE_W-1:0] c, output t_result r);
        r = '0;
        case (scan_phase)
            SCAN_NAME: begin
                if (c == END_CH) begin
                    if (name_len >= NAME_BYTES) return close_line(r, STATUS_ERR, 0, 0, 0);
                    return close_ok(r);
                end
                if (is_blank(c)) begin
                    // an overlong name keeps swallowing until the terminator
                    if (name_len < NAME_BYTES) scan_phase = SCAN_GAP1;
                    return 1'b0;
                end
                return name_char(r, c);
            end
            SCAN_GAP1: begin
                if (c == END_CH) return close_ok(r);
                if (is_blank(c)) return 1'b0;
                if (c == QUOTE_CH) begin
                    scan_phase = SCAN_QUOTED;
                    return 1'b0;
                end
                scan_phase = SCAN_BARE;
                return first_char(r, c);
            end
            SCAN_QUOTED: begin
                if (c == END_CH) return close_line(r, STATUS_ERR, name_len, 0, 0);
                if (c == QUOTE_CH) begin
                    scan_phase = SCAN_GAP2;
                    return 1'b0;
                end
                return first_char(r, c);
            end
            SCAN_BARE: begin
                if (c == END_CH) return close_ok(r);
                if (is_blank(c)) begin
                    scan_phase = SCAN_GAP2;
                    return 1'b0;
                end
                return first_char(r, c);
            end
            SCAN_GAP2: begin
                if (c == END_CH) return close_ok(r);
                if (is_blank(c)) return 1'b0;
                scan_phase = SCAN_TAIL;
                return second_char(r, c);
            end
            SCAN_TAIL: begin
                if (c == END_CH) return close_ok(r);
                return second_char(r, c);
            end
            default: begin
                if (c == END_CH) return close_line(r, STATUS_ERR, 0, 0, 0);
                if (is_blank(c)) begin
                    scan_phase = SCAN_LEAD;
                    return 1'b0;
                end
                scan_phase = SCAN_NAME;
                name_len   = 0;
                first_len  = 0;
                second_len = 0;
                return name_char(r, c);
            end
        endcase
    endfunction

    function automatic int field_diff(input string label, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, exp_v, act_v);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            scan_phase = SCAN_LEAD;
            name_len   = 0;
            first_len  = 0;
            second_len = 0;
            fails      = 0;
            token_beats.delete();
        end else begin
            if (i_in.valid && i_in.ready) begin
                if (tokenize_byte(i_in.in_byte, want)) token_beats.push_back(want);
            end
            if (i_out.valid && i_out.ready) begin
                seen = {i_out.is_status, i_out.field_id, i_out.char_index, i_out.char_value,
                        i_out.status_code, i_out.name_length, i_out.first_arg_length,
                        i_out.second_arg_length};
                if (token_beats.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, actual %h", $time, seen);
                    fails++;
                end else begin
                    want = token_beats.pop_front();
                    fails += field_diff("is_status", want.is_status, seen.is_status);
                    fails += field_diff("field_id", want.field_id, seen.field_id);
                    fails += field_diff("char_index", want.char_index, seen.char_index);
                    fails += field_diff("char_value", want.char_value, seen.char_value);
                    fails += field_diff("status_code", want.status_code, seen.status_code);
                    fails += field_diff("name_length", want.name_length, seen.name_length);
                    fails += field_diff("first_arg_length", want.first_arg_length,
                                        seen.first_arg_length);
                    fails += field_diff("second_arg_length", want.second_arg_length,
                                        seen.second_arg_length);
                end
            end
        end
        o_tokens_pending <= token_beats.size();
        o_fail_count     <= fails;
    end

endmodule

>>> tb/sv/command_line_tokenizer_unit_test.sv
module command_line_tokenizer_unit_test;
    import clt_pkg::*;

    localparam int ITEM_TARGET  = 750;
    localparam int DRAIN_CYCLES = 20;
    localparam logic [BYTE_W-1:0] LOWER_A = 8'h61;

    // empty line; blank lead, case edges, quoted arg1 then arg2 hard against the
    // closing quote; unclosed quote; bare arg1 then arg2 with inner blanks
    localparam logic [BYTE_W-1:0] DIRECTED [26] = '{
        END_CH,
        8'h20, "a", "Z", "{", 8'hFF, 8'h09, QUOTE_CH, "q", 8'h20, QUOTE_CH, "x", END_CH,
        "b", 8'h0B, QUOTE_CH, "r", END_CH,
        "c", 8'h20, "d", 8'h0D, "e", 8'h20, "f", END_CH
    };

    typedef enum int {ARG_NONE, ARG_BARE, ARG_QUOTED, ARG_OPEN} arg_form_e;

    logic              i_clk;
    logic              i_rst_n;
    int                fail_count;
    int                tokens_pending;
    int                sent;
    bit                quiet;
    logic [BYTE_W-1:0] line_q[$];

    clt_byte_if   in_if ();
    clt_result_if out_if ();

    command_line_tokenizer_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    command_line_tokenizer_unit_checker i_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in             (in_if),
        .i_out            (out_if),
        .o_fail_count     (fail_count),
        .o_tokens_pending (tokens_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

    // result side back-pressure
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            out_if.ready <= quiet || ($urandom_range(99) >= 16);
        end
    end

    function automatic logic [BYTE_W-1:0] pick_space();
        int k;
        k = $urandom_range(5);
        if (k == 5) return 8'h20;
        return 8'h09 + 8'(k);
    endfunction

    function automatic logic [BYTE_W-1:0] pick_graphic(input bit allow_quote);
        logic [BYTE_W-1:0] c;
        if ($urandom_range(1) != 0) return LOWER_A + 8'($urandom_range(25));
        do c = 8'($urandom_range(1, 255));
        while (is_ws(c) || (!allow_quote && (c == QUOTE_CH)));
        return c;
    endfunction

    function automatic logic [BYTE_W-1:0] pick_filler(input bit allow_quote);
        logic [BYTE_W-1:0] c;
        if ($urandom_range(3) == 0) return pick_space();
        do c = 8'($urandom_range(1, 255));
        while (!allow_quote && (c == QUOTE_CH));
        return c;
    endfunction

    function automatic arg_form_e pick_form();
        int k;
        k = $urandom_range(9);
        if (k == 0) return ARG_NONE;
        if (k < 5) return ARG_BARE;
        if (k < 9) return ARG_QUOTED;
        return ARG_OPEN;
    endfunction

    task automatic add_line(input int name_n, input arg_form_e form, input int a1_n,
                            input int a2_n);
        repeat ($urandom_range(2)) line_q.push_back(pick_space());
        repeat (name_n) line_q.push_back(pick_graphic(1'b1));
        if (form != ARG_NONE) begin
            repeat ($urandom_range(1, 2)) line_q.push_back(pick_space());
            if (form == ARG_BARE) begin
                repeat (a1_n) line_q.push_back(pick_graphic(1'b0));
            end else begin
                line_q.push_back(QUOTE_CH);
                repeat (a1_n) line_q.push_back(pick_filler(1'b0));
                if (form == ARG_QUOTED) line_q.push_back(QUOTE_CH);
            end
            if ((form != ARG_OPEN) && (a2_n > 0)) begin
                // a bare arg1 needs a blank before arg2, a closing quote does not
                repeat ((form == ARG_BARE) ? $urandom_range(1, 2) : $urandom_range(2))
                    line_q.push_back(pick_space());
                line_q.push_back(pick_graphic(1'b1));
                repeat (a2_n - 1) line_q.push_back(pick_filler(1'b1));
            end
        end
        line_q.push_back(END_CH);
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while (!quiet && ($urandom_range(99) < 16)) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.in_byte <= b;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        sent++;
    endtask

    task automatic send_line();
        while (line_q.size() != 0) send_byte(line_q.pop_front());
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (tokens_pending != 0) @(posedge i_clk);
    endtask

    initial begin
        int pick;
        i_rst_n       = 1'b0;
        in_if.valid   = 1'b0;
        in_if.in_byte = '0;
        sent          = 0;
        quiet         = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[k]) line_q.push_back(DIRECTED[k]);
        send_line();
        wait_drained();

        while (sent < ITEM_TARGET) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                // raw noise, terminators included
                repeat ($urandom_range(1, 12))
                    line_q.push_back(($urandom_range(7) == 0) ? END_CH : 8'($urandom_range(255)));
                line_q.push_back(END_CH);
            end else if (pick < 11) begin
                add_line($urandom_range(NAME_BYTES - 1, NAME_BYTES + 3), pick_form(),
                         $urandom_range(1, 6), $urandom_range(0, 6));
            end else if (pick < 13) begin
                add_line($urandom_range(1, 6),
                         ($urandom_range(1) != 0) ? ARG_BARE : ARG_QUOTED,
                         $urandom_range(FIRST_ARG_BYTES - 2, FIRST_ARG_BYTES + 4),
                         $urandom_range(0, 4));
            end else if (pick < 15) begin
                add_line($urandom_range(1, 6), ARG_QUOTED, $urandom_range(0, 6),
                         $urandom_range(SECOND_ARG_BYTES - 2, SECOND_ARG_BYTES + 4));
            end else if (pick < 22) begin
                add_line($urandom_range(1, 8), ARG_OPEN, $urandom_range(0, 6), 0);
            end else if (pick < 27) begin
                add_line(0, ARG_NONE, 0, 0);
            end else begin
                add_line($urandom_range(1, 8), pick_form(), $urandom_range(1, 8),
                         $urandom_range(0, 10));
            end
            send_line();
            quiet = (sent >= 300) && (sent < 450);
            if ($urandom_range(19) == 0) wait_drained();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+src
src/clt_pkg.sv
src/clt_ifs.sv
src/clt_parse.sv
src/command_line_tokenizer_unit.sv
tb/sv/command_line_tokenizer_unit_checker.sv
tb/sv/command_line_tokenizer_unit_test.sv
